@@ hw/rtl/lpc_pkg.sv @@
// shared constants, types and register codes for the local peak clip filter
// no dependencies; every other rtl file but lpc_ram imports this package

package lpc_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int PIXEL_BITS   = 16;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int ADDR_BITS = $clog2(MAX_WIDTH);
	localparam int CNT_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int FW_BITS   = 11;
	localparam int FH_BITS   = 13;
	localparam int ROW_BITS  = 12;
	localparam int FW_CMP    = (FW_BITS > CNT_BITS) ? FW_BITS : CNT_BITS;

	localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(1024);
	localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(1024);

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;

	// register index, taken from the word address bit
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// request codes
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	// one classified pixel with its neighborhood, front to back
	typedef struct packed {
		pixel_t center;
		pixel_t left;
		pixel_t right;
		pixel_t up;
		pixel_t down;
		logic   has_left;
		logic   has_up;
		logic   has_right;
		logic   has_down;
		logic   row_end;
		logic   frame_end;
	} lpc_item_t;

	// effective frame geometry and restart pulse from the register block
	typedef struct packed {
		logic [CNT_BITS-1:0] width;
		logic [FH_BITS-1:0]  height;
		logic                restart;
	} lpc_frame_t;

endpackage

@@ hw/rtl/lpc_ram.sv @@
// generic one-write one-read ram with registered read data
// a read of the address being written returns the new data; no dependencies

module lpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem_q[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lpc_front.sv @@
// front end: accepts requests, tracks raster position and drain count,
// owns both line stores and the three-tap row window; uses lpc_pkg, lpc_ram

module lpc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  lpc_pkg::lpc_frame_t frame,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               req_type,
	input  lpc_pkg::pixel_t    pixel_in,
	output logic               push,
	output lpc_pkg::lpc_item_t push_item,
	input  logic               full
);

	import lpc_pkg::*;

	logic [ADDR_BITS-1:0] col_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [CNT_BITS-1:0]  drain_left_q;

	logic                 is_drain;
	logic                 live;
	logic                 accept;
	logic                 take;
	logic [CNT_BITS-1:0]  c_drn;
	logic [ADDR_BITS-1:0] c;
	logic [CNT_BITS-1:0]  c_next;
	logic                 has_right;
	logic                 row_end;
	logic                 last_row;

	logic                 valid_s1;
	logic                 pixel_s1;
	logic                 emit_s1;
	logic [ADDR_BITS-1:0] c_s1;
	logic                 has_left_s1;
	logic                 has_up_s1;
	logic                 has_right_s1;
	logic                 row_end_s1;
	logic                 frame_end_s1;
	pixel_t               down_s1;
	logic                 adv_s1;

	pixel_t               left_q;
	pixel_t               cent_q;
	pixel_t               mid_rdata;
	pixel_t               up_rdata;

	assign is_drain = (req_type == REQ_DRAIN);
	assign live     = is_drain ? (drain_left_q != '0) : (drain_left_q == '0);
	assign accept   = req_valid && !req_stall;
	assign take     = accept && live;

	assign c_drn = frame.width - drain_left_q;

	always_comb begin
		if (is_drain) begin
			c = c_drn[ADDR_BITS-1:0];
		end else if (CNT_BITS'(col_q) >= frame.width) begin
			c = '0;
		end else begin
			c = col_q;
		end
	end

	assign c_next    = CNT_BITS'(c) + CNT_BITS'(1);
	assign has_right = (c_next < frame.width);
	assign row_end   = (c_next == frame.width);
	assign last_row  = ((FH_BITS'(row_q) + FH_BITS'(1)) >= frame.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			drain_left_q <= '0;
		end else if (frame.restart) begin
			col_q        <= '0;
			row_q        <= '0;
			drain_left_q <= '0;
		end else if (take) begin
			if (is_drain) begin
				drain_left_q <= drain_left_q - CNT_BITS'(1);
			end else if (row_end) begin
				col_q <= '0;
				if (last_row) begin
					row_q        <= '0;
					drain_left_q <= frame.width;
				end else begin
					row_q <= row_q + ROW_BITS'(1);
				end
			end else begin
				col_q <= c_next[ADDR_BITS-1:0];
			end
		end
	end

	// s1 only waits when it has a result and the queue is full
	assign adv_s1    = valid_s1 && (!emit_s1 || !full);
	assign req_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= live;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_s1     <= !is_drain;
			emit_s1      <= is_drain || (row_q != '0);
			c_s1         <= c;
			has_left_s1  <= (c != '0);
			has_up_s1    <= is_drain ? (frame.height >= FH_BITS'(2)) : (row_q >= ROW_BITS'(2));
			has_right_s1 <= has_right;
			row_end_s1   <= row_end;
			frame_end_s1 <= is_drain && row_end;
			down_s1      <= pixel_in;
		end
	end

	// window: left and center come from earlier reads, right is this read
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_q <= cent_q;
			cent_q <= mid_rdata;
		end
	end

	// middle row: write the new pixel, fetch the next column (column 0 at row end)
	lpc_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (take && !is_drain),
		.waddr (c),
		.wdata (pixel_in),
		.re    (take),
		.raddr (has_right ? c_next[ADDR_BITS-1:0] : ADDR_BITS'(0)),
		.rdata (mid_rdata)
	);

	// upper row takes the old middle value once it is in the window
	lpc_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (adv_s1 && pixel_s1),
		.waddr (c_s1),
		.wdata (cent_q),
		.re    (take),
		.raddr (c),
		.rdata (up_rdata)
	);

	assign push = adv_s1 && emit_s1;

	always_comb begin
		push_item.center    = cent_q;
		push_item.left      = left_q;
		push_item.right     = mid_rdata;
		push_item.up        = up_rdata;
		push_item.down      = down_s1;
		push_item.has_left  = has_left_s1;
		push_item.has_up    = has_up_s1;
		push_item.has_right = has_right_s1;
		push_item.has_down  = pixel_s1;
		push_item.row_end   = row_end_s1;
		push_item.frame_end = frame_end_s1;
	end

`ifndef NO_ASSERTIONS
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_BITS'(col_q) < frame.width)
		else $error("column position beyond frame width");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain_left_q <= frame.width)
		else $error("drain count beyond frame width");

	a_drain_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_left_q != '0) |-> (col_q == '0 && row_q == '0))
		else $error("drain pending while not at frame origin");
`endif

endmodule

@@ hw/rtl/lpc_queue.sv @@
// short flop queue of classified pixels between front and back
// uses lpc_pkg for the item type and depth

module lpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpc_pkg::lpc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output lpc_pkg::lpc_item_t head,
	output logic               empty
);

	import lpc_pkg::*;

	lpc_item_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
		logic [QPTR_BITS-1:0] r;
		if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_BITS'(1);
		end
		return r;
	endfunction

	assign full  = (count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_BITS + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_BITS + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ hw/rtl/lpc_back.sv @@
// back end: clips each pixel above its existing neighbors to the largest of
// them over two stages and holds the result beat until taken; uses lpc_pkg

module lpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lpc_pkg::lpc_item_t head,
	input  logic               empty,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output lpc_pkg::pixel_t    pixel_out,
	output logic               row_end,
	output logic               frame_end
);

	import lpc_pkg::*;

	logic   valid_s2;
	pixel_t center_s2;
	pixel_t m01_s2;
	pixel_t m23_s2;
	logic   v01_s2;
	logic   v23_s2;
	logic   row_end_s2;
	logic   frame_end_s2;

	logic   valid_s3;
	pixel_t pixel_s3;
	logic   row_end_s3;
	logic   frame_end_s3;

	logic   out_free;
	logic   adv_s2;
	pixel_t m01;
	pixel_t m23;
	pixel_t mx;
	logic   any;

	assign out_free = !valid_s3 || !res_stall;
	assign adv_s2   = !valid_s2 || out_free;
	assign pop      = !empty && adv_s2;

	// pairwise max, an absent neighbor never wins
	assign m01 = (head.has_left && (!head.has_up || head.left > head.up)) ? head.left : head.up;
	assign m23 = (head.has_right && (!head.has_down || head.right > head.down)) ?
		head.right : head.down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			center_s2    <= head.center;
			m01_s2       <= m01;
			m23_s2       <= m23;
			v01_s2       <= head.has_left || head.has_up;
			v23_s2       <= head.has_right || head.has_down;
			row_end_s2   <= head.row_end;
			frame_end_s2 <= head.frame_end;
		end
	end

	assign mx  = (v01_s2 && (!v23_s2 || m01_s2 > m23_s2)) ? m01_s2 : m23_s2;
	assign any = v01_s2 || v23_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			pixel_s3     <= (any && center_s2 > mx) ? mx : center_s2;
			row_end_s3   <= row_end_s2;
			frame_end_s3 <= frame_end_s2;
		end
	end

	assign res_valid = valid_s3;
	assign pixel_out = pixel_s3;
	assign row_end   = row_end_s3;
	assign frame_end = frame_end_s3;

`ifndef NO_ASSERTIONS
	a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && frame_end_s3) |-> row_end_s3)
		else $error("frame end flagged off a row end");
`endif

endmodule

@@ hw/rtl/local_peak_clip_filter.sv @@
// top level of the local peak clip filter: register block, front, queue, back
// uses lpc_pkg, lpc_front (with its lpc_ram line stores), lpc_queue, lpc_back

// Raster-order pixel filter: each pixel above all of its existing four
// neighbors is clipped to the largest of them. One request beat (pixel or
// drain) is taken per clock while req_stall is low, set by the single write
// and read port of each line store used once per beat. A result beat passes
// s1, the queue, s2 and s3 after the request that releases it: the pixel
// below releases a pixel, and after the last row one drain beat releases
// each last-row pixel. Pixels sent while a drain is pending and drains with
// nothing pending are taken and dropped. The two 1024 x 16 line stores have
// no clearing pass and are ready right after reset. Writing frame_width or
// frame_height restarts the frame; write them only while the block is idle.

module local_peak_clip_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lpc_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [lpc_pkg::CFG_DATA_BITS-1:0]    pwdata,
	output logic [lpc_pkg::CFG_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 req_type,
	input  logic [lpc_pkg::PIXEL_BITS-1:0]       pixel_in,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [lpc_pkg::PIXEL_BITS-1:0]       pixel_out,
	output logic                                 row_end,
	output logic                                 frame_end
);

	import lpc_pkg::*;

	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic               cfg_wr;
	logic [FW_CMP-1:0]  fw_x;
	lpc_frame_t         frame;

	logic      push;
	lpc_item_t push_item;
	logic      full;
	logic      pop;
	lpc_item_t head;
	logic      empty;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			case (paddr[CFG_ADDR_BITS-1])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_BITS-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[CFG_ADDR_BITS-1])
			REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// out-of-range geometry clamps to the nearest legal size
	assign fw_x = FW_CMP'(frame_width_q);

	always_comb begin
		if (fw_x == '0) begin
			frame.width = CNT_BITS'(1);
		end else if (fw_x > FW_CMP'(MAX_WIDTH)) begin
			frame.width = CNT_BITS'(MAX_WIDTH);
		end else begin
			frame.width = CNT_BITS'(fw_x);
		end
		if (frame_height_q == '0) begin
			frame.height = FH_BITS'(1);
		end else if (frame_height_q > FH_BITS'(HEIGHT_LIMIT)) begin
			frame.height = FH_BITS'(HEIGHT_LIMIT);
		end else begin
			frame.height = frame_height_q;
		end
		frame.restart = cfg_wr;
	end

	lpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.pixel_in  (pixel_in),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	lpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	lpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_out (pixel_out),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule
